[rtl/core/tpcd_pkg.sv]
// Package for the telemetry point change detector.
// Holds field widths, register indexes, the sequencer state type and constants.
// No dependencies.
`default_nettype none
package tpcd_pkg;

  localparam int TableEntriesDef = 1024;

  localparam int OpW    = 2;
  localparam int GwW    = 8;
  localparam int CaW    = 16;
  localparam int OaW    = 24;
  localparam int ValW   = 48;
  localparam int QualW  = 8;
  localparam int DeltaW = 49;
  localparam int KeyW   = OpW + GwW + CaW + OaW;
  localparam int AbsW   = 47;
  localparam int RateW  = 32;

  localparam int InDataW  = 104;
  localparam int OutDataW = 56;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 64;

  // point kinds
  localparam logic [OpW-1:0] OpStatus = 2'd0;
  localparam logic [OpW-1:0] OpMeas   = 2'd1;
  localparam logic [OpW-1:0] OpEnergy = 2'd2;
  localparam logic [OpW-1:0] OpNone   = 2'd3;

  // register indexes (byte address bit 3)
  localparam logic RegAbs  = 1'b0;
  localparam logic RegRate = 1'b1;

  // scaling constants of the downward ratio rule
  localparam logic [31:0] DownScale = 32'd1024000000;
  localparam logic [31:0] NewScale  = 32'd15625;
  localparam logic [63:0] NewOffset = 64'd1024;

  localparam logic [3:0] MulLastStep = 4'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_MISS,
    ST_DATA_RD,
    ST_DATA_CMP,
    ST_MUL,
    ST_RATIO,
    ST_UPDATE,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

[rtl/core/telemetry_point_change_detector.sv]
// Telemetry point change detector, top level.
// Uses tpcd_pkg for widths, codes and the sequencer state type.
//
// Use: point updates enter on the in_ stream (in_tuser = point kind, in_tdata =
// gateway id, station address, object address, value, quality). Each item gives
// one result on the out_ stream: status, first_seen, changed, spike, delta.
// Thresholds are written over the cfg_ APB port (abs at 0x0, rate at 0x8).
// The block takes one item at a time. The key table is searched linearly in a
// one-port key memory, with a read state and a compare state per stored point.
// On a hit the stored value and quality are read and compared; on a miss the
// key is appended and its data written; when the table is full the result
// only sets status. An item of the unused kind goes straight to its result.
// The sequencer returns to idle before the next item is taken.
// Energy updates with a positive previous value and a non-negative new value
// also compute the ratio products on one 32x32 multiplier.
// Reset clears the fill count, the sequencer and the result valid flag; the
// table memories are not cleared, the fill count guards every read.
// When the receiver stalls, the result stays in the output register and the
// next item is taken but held at its last step until the register frees.
`default_nettype none
module telemetry_point_change_detector #(
  parameter int TABLE_ENTRIES = tpcd_pkg::TableEntriesDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // gateway_id[7:0], station_addr[23:8], object_address[47:24],
  // point_value[95:48], quality[103:96]
  input  wire logic [tpcd_pkg::InDataW-1:0]  in_tdata,
  // op[1:0]
  input  wire logic [tpcd_pkg::OpW-1:0]      in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // status[0], first_seen[1], changed[2], spike[3], delta[52:4], zero[55:53]
  output logic [tpcd_pkg::OutDataW-1:0]      out_tdata,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [tpcd_pkg::CfgAddrW-1:0] cfg_paddr,
  input  wire logic [tpcd_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [tpcd_pkg::CfgDataW-1:0]      cfg_prdata,
  output logic                               cfg_pready
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] FullCount = CW'(TABLE_ENTRIES);

  localparam int KeyW  = tpcd_pkg::KeyW;
  localparam int ValW  = tpcd_pkg::ValW;
  localparam int QualW = tpcd_pkg::QualW;
  localparam int DW    = tpcd_pkg::DeltaW;

  // configuration registers
  logic [tpcd_pkg::AbsW-1:0]  abs_thr_r;
  logic [tpcd_pkg::RateW-1:0] rate_thr_r;
  logic                       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_thr_r  <= '1;
      rate_thr_r <= '1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3])
        tpcd_pkg::RegAbs:  abs_thr_r  <= cfg_pwdata[tpcd_pkg::AbsW-1:0];
        tpcd_pkg::RegRate: rate_thr_r <= cfg_pwdata[tpcd_pkg::RateW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3])
      tpcd_pkg::RegAbs:  cfg_prdata = {{(64-tpcd_pkg::AbsW){1'b0}}, abs_thr_r};
      tpcd_pkg::RegRate: cfg_prdata = {32'd0, rate_thr_r};
      default:           cfg_prdata = '0;
    endcase
  end

  // state and item registers
  tpcd_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r;
  logic [AW-1:0]   idx_r;
  logic [AW-1:0]   slot_r;
  logic [KeyW-1:0] key_r;
  logic [ValW-1:0] val_r;
  logic [QualW-1:0] qual_r;
  logic            first_r, changed_r, spike_r, status_r;
  logic [DW-1:0]   delta_r;
  logic [ValW-1:0] prev_r;
  logic            out_valid_r;
  logic [tpcd_pkg::OutDataW-1:0] out_data_r;

  // table memories
  logic [KeyW-1:0]       key_mem  [TABLE_ENTRIES];
  logic [QualW+ValW-1:0] data_mem [TABLE_ENTRIES];
  logic [KeyW-1:0]       key_rd_r;
  logic [QualW+ValW-1:0] data_rd_r;
  logic [AW-1:0]         key_addr, data_addr;
  logic                  key_we, data_we;

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_addr] <= key_r;
    key_rd_r <= key_mem[key_addr];
  end

  always_ff @(posedge clk) begin
    if (data_we) data_mem[data_addr] <= {qual_r, val_r};
    data_rd_r <= data_mem[data_addr];
  end

  // lookup helpers
  logic          in_acc, key_hit, scan_last, table_full, out_free;
  logic [CW-1:0] idx_inc;
  logic [ValW-1:0]  prev_val;
  logic [QualW-1:0] prev_qual;
  logic          prev_pos, val_nonneg;
  logic [DW-1:0] delta_c, mag_c;

  assign in_acc     = in_tvalid && in_tready;
  assign key_hit    = key_rd_r == key_r;
  assign idx_inc    = {1'b0, idx_r} + CW'(1);
  assign scan_last  = idx_inc == count_r;
  assign table_full = count_r == FullCount;
  assign out_free   = !out_valid_r || out_tready;
  assign prev_val   = data_rd_r[ValW-1:0];
  assign prev_qual  = data_rd_r[QualW+ValW-1:ValW];
  assign prev_pos   = !prev_val[ValW-1] && (prev_val != '0);
  assign val_nonneg = !val_r[ValW-1];
  assign delta_c    = {val_r[ValW-1], val_r} - {prev_val[ValW-1], prev_val};
  assign mag_c      = delta_c[DW-1] ? (DW'(0) - delta_c) : delta_c;

  // ratio products on one shared 32x32 multiplier
  logic [3:0]  step_r;
  logic [2:0]  pp_sel_r;
  logic        pp_vld_r;
  logic [63:0] pp_r;
  logic [31:0] mul_a, mul_b;
  logic [63:0] acc_w_r, w_r;
  logic [79:0] acc_r_r;
  logic [79:0] acc_p_r;
  logic [95:0] acc_d_r;
  logic        up_hit, down_hit;

  // pick operands for this step
  always_comb begin
    case (step_r[2:0])
      3'd0:    begin mul_a = val_r[31:0];                 mul_b = tpcd_pkg::NewScale;  end
      3'd1:    begin mul_a = {17'd0, val_r[46:32]};       mul_b = tpcd_pkg::NewScale;  end
      3'd2:    begin mul_a = prev_r[31:0];                mul_b = rate_thr_r;          end
      3'd3:    begin mul_a = {17'd0, prev_r[46:32]};      mul_b = rate_thr_r;          end
      3'd4:    begin mul_a = prev_r[31:0];                mul_b = tpcd_pkg::DownScale; end
      3'd5:    begin mul_a = {17'd0, prev_r[46:32]};      mul_b = tpcd_pkg::DownScale; end
      3'd6:    begin mul_a = w_r[31:0];                   mul_b = rate_thr_r;          end
      default: begin mul_a = w_r[63:32];                  mul_b = rate_thr_r;          end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_vld_r <= 1'b0;
    end else begin
      pp_vld_r <= (state_r == tpcd_pkg::ST_MUL) && (step_r != tpcd_pkg::MulLastStep);
    end
  end

  // multiply, then accumulate the registered partial product in the next cycle
  always_ff @(posedge clk) begin
    pp_r     <= mul_a * mul_b;
    pp_sel_r <= step_r[2:0];
    if (state_r == tpcd_pkg::ST_MUL && step_r == 4'd4) w_r <= acc_w_r + tpcd_pkg::NewOffset;
    if (pp_vld_r) begin
      case (pp_sel_r)
        3'd0:    acc_w_r <= pp_r;
        3'd1:    acc_w_r <= acc_w_r + {pp_r[31:0], 32'd0};
        3'd2:    acc_r_r <= {16'd0, pp_r};
        3'd3:    acc_r_r <= acc_r_r + {pp_r[47:0], 32'd0};
        3'd4:    acc_p_r <= {16'd0, pp_r};
        3'd5:    acc_p_r <= acc_p_r + {pp_r[47:0], 32'd0};
        3'd6:    acc_d_r <= {32'd0, pp_r};
        default: acc_d_r <= acc_d_r + {pp_r, 32'd0};
      endcase
    end
  end

  assign up_hit   = {16'd0, val_r, 16'd0} >= acc_r_r;
  assign down_hit = {16'd0, acc_p_r} >= acc_d_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tpcd_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == tpcd_pkg::OpNone) state_nxt = tpcd_pkg::ST_FIN;
          else if (count_r == '0)           state_nxt = tpcd_pkg::ST_MISS;
          else                              state_nxt = tpcd_pkg::ST_SCAN_RD;
        end
      end
      tpcd_pkg::ST_SCAN_RD:  state_nxt = tpcd_pkg::ST_SCAN_CMP;
      tpcd_pkg::ST_SCAN_CMP: begin
        if (key_hit)        state_nxt = tpcd_pkg::ST_DATA_RD;
        else if (scan_last) state_nxt = tpcd_pkg::ST_MISS;
        else                state_nxt = tpcd_pkg::ST_SCAN_RD;
      end
      tpcd_pkg::ST_MISS:     state_nxt = table_full ? tpcd_pkg::ST_FIN : tpcd_pkg::ST_UPDATE;
      tpcd_pkg::ST_DATA_RD:  state_nxt = tpcd_pkg::ST_DATA_CMP;
      tpcd_pkg::ST_DATA_CMP: begin
        if (key_r[KeyW-1 -: 2] == tpcd_pkg::OpEnergy && prev_pos && val_nonneg)
          state_nxt = tpcd_pkg::ST_MUL;
        else
          state_nxt = tpcd_pkg::ST_UPDATE;
      end
      tpcd_pkg::ST_MUL: begin
        if (step_r == tpcd_pkg::MulLastStep) state_nxt = tpcd_pkg::ST_RATIO;
      end
      tpcd_pkg::ST_RATIO:  state_nxt = tpcd_pkg::ST_UPDATE;
      tpcd_pkg::ST_UPDATE: state_nxt = tpcd_pkg::ST_FIN;
      tpcd_pkg::ST_FIN: begin
        if (out_free) state_nxt = tpcd_pkg::ST_IDLE;
      end
      default: state_nxt = tpcd_pkg::ST_IDLE;
    endcase
  end

  // memory control and handshake outputs
  always_comb begin
    in_tready = 1'b0;
    key_addr  = idx_r;
    data_addr = slot_r;
    key_we    = 1'b0;
    data_we   = 1'b0;
    unique case (state_r)
      tpcd_pkg::ST_IDLE:   in_tready = 1'b1;
      tpcd_pkg::ST_MISS: begin
        key_addr = count_r[AW-1:0];
        key_we   = !table_full;
      end
      tpcd_pkg::ST_UPDATE: data_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpcd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // fill count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == tpcd_pkg::ST_MISS && !table_full) count_r <= count_r + CW'(1);
      if (state_r == tpcd_pkg::ST_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_tready)                         out_valid_r <= 1'b0;
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      tpcd_pkg::ST_IDLE: begin
        key_r     <= {in_tuser, in_tdata[7:0], in_tdata[23:8], in_tdata[47:24]};
        val_r     <= in_tdata[95:48];
        qual_r    <= in_tdata[103:96];
        idx_r     <= '0;
        first_r   <= 1'b0;
        changed_r <= 1'b0;
        spike_r   <= 1'b0;
        status_r  <= 1'b0;
        delta_r   <= '0;
        step_r    <= '0;
      end
      tpcd_pkg::ST_SCAN_CMP: begin
        slot_r <= idx_r;
        idx_r  <= idx_inc[AW-1:0];
      end
      tpcd_pkg::ST_MISS: begin
        slot_r    <= count_r[AW-1:0];
        status_r  <= table_full;
        first_r   <= !table_full;
        changed_r <= !table_full && (key_r[KeyW-1 -: 2] != tpcd_pkg::OpEnergy);
      end
      tpcd_pkg::ST_DATA_CMP: begin
        prev_r <= prev_val;
        if (key_r[KeyW-1 -: 2] != tpcd_pkg::OpEnergy) begin
          changed_r <= (prev_val != val_r) || (prev_qual != qual_r);
        end else begin
          delta_r <= delta_c;
          spike_r <= mag_c >= {2'b00, abs_thr_r};
        end
      end
      tpcd_pkg::ST_MUL: begin
        if (step_r != tpcd_pkg::MulLastStep) step_r <= step_r + 4'd1;
      end
      tpcd_pkg::ST_RATIO: spike_r <= spike_r || up_hit || down_hit;
      tpcd_pkg::ST_FIN: begin
        if (out_free)
          out_data_r <= {3'd0, delta_r, spike_r, changed_r, first_r, status_r};
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
